// ----- rtl/core/lcdt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd timing package
// widths, register indexes, mode codes and reset values shared by the
// lcd mode and line timing block
// ----------------------------------------------------------------------------
package lcdt_pkg;

    // default line geometry
    localparam int VISIBLE_LINES_DEF = 144;
    localparam int TOTAL_LINES_DEF   = 154;

    // field widths
    localparam int DELTA_W     = 8;
    localparam int LINE_W      = 8;
    localparam int LINE_CYC_W  = 10;
    localparam int MODE_DUR_W  = 13;
    localparam int LINE_CNT_W  = 11;
    localparam int MODE_CNT_W  = 14;
    localparam int IRQ_EN_W    = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;

    // counter saturation limits
    localparam logic [LINE_CNT_W-1:0] LINE_CNT_MAX = '1;
    localparam logic [MODE_CNT_W-1:0] MODE_CNT_MAX = '1;

    // register reset values
    localparam logic [LINE_CYC_W-1:0] LINE_CYCLES_RST = 10'd456;
    localparam logic [MODE_DUR_W-1:0] OAM_CYCLES_RST  = 13'd80;
    localparam logic [MODE_DUR_W-1:0] XFER_CYCLES_RST = 13'd172;
    localparam logic [MODE_DUR_W-1:0] HBL_CYCLES_RST  = 13'd204;
    localparam logic [MODE_DUR_W-1:0] VBL_CYCLES_RST  = 13'd4560;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_CYCLES  = 3'd0,
        CFG_OAM_CYCLES   = 3'd1,
        CFG_XFER_CYCLES  = 3'd2,
        CFG_HBL_CYCLES   = 3'd3,
        CFG_VBL_CYCLES   = 3'd4,
        CFG_LYC_VALUE    = 3'd5,
        CFG_IRQ_ENABLES  = 3'd6
    } cfg_index_t;

    // stat interrupt enable bit positions
    localparam int IRQ_EN_HBLANK = 0;
    localparam int IRQ_EN_VBLANK = 1;
    localparam int IRQ_EN_OAM    = 2;
    localparam int IRQ_EN_LYC    = 3;

    // externally visible mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // mode sequencer state, one-hot
    typedef enum logic [3:0] {
        ST_OAM    = 4'b0001,
        ST_XFER   = 4'b0010,
        ST_HBLANK = 4'b0100,
        ST_VBLANK = 4'b1000
    } mode_state_t;

    // result word
    typedef struct packed {
        logic       new_line;
        logic       draw_request;
        logic       stat_irq;
        logic       vblank_irq;
        logic       line_match;
        logic [1:0] mode;
        logic [7:0] scanline;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_state_t st);
        logic [1:0] code;
        unique case (st)
            ST_OAM:    code = MODE_OAM;
            ST_XFER:   code = MODE_XFER;
            ST_HBLANK: code = MODE_HBLANK;
            ST_VBLANK: code = MODE_VBLANK;
            default:   code = MODE_OAM;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/lcd_mode_and_line_timing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd mode and line timing
// results: each result word is registered in the output register, or parked in the skid register on a stall
// throughput: one word per cycle while the skid register is empty, set by the single add/compare pass on state
// an output register plus a skid register let input continue for one stalled word
// reset: asynchronous, active low; line 0, oam scan, counters zero, defaults loaded
// ----------------------------------------------------------------------------
module lcd_mode_and_line_timing #(
    parameter int VISIBLE_LINES = lcdt_pkg::VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES   = lcdt_pkg::TOTAL_LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcdt_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] elapsed_cycles
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] scanline, [9:8] mode, [10] line_match, [11] vblank_irq,
    // [12] stat_irq, [13] draw_request, [14] new_line, [15] zero
    output logic [lcdt_pkg::OUT_DATA_W-1:0] m_tdata,
    // register write port
    input  logic                            cfg_we,
    input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lcdt_pkg::*;

    // line geometry in the width of an incremented line number
    localparam logic [LINE_W:0] VisLines   = (LINE_W+1)'(VISIBLE_LINES);
    localparam logic [LINE_W:0] TotalLines = (LINE_W+1)'(TOTAL_LINES);

    // configuration registers
    logic [LINE_CYC_W-1:0] line_cycles_reg;
    logic [MODE_DUR_W-1:0] oam_cycles_reg;
    logic [MODE_DUR_W-1:0] xfer_cycles_reg;
    logic [MODE_DUR_W-1:0] hbl_cycles_reg;
    logic [MODE_DUR_W-1:0] vbl_cycles_reg;
    logic [LINE_W-1:0]     lyc_value_reg;
    logic [IRQ_EN_W-1:0]   irq_en_reg;

    // timing state
    logic [LINE_CNT_W-1:0] line_cnt_reg, line_cnt_next;
    logic [MODE_CNT_W-1:0] mode_cnt_reg, mode_cnt_next;
    logic [LINE_W-1:0]     line_reg, line_next;
    mode_state_t           mode_reg, mode_next;
    logic                  vbl_fired_reg, vbl_fired_next;
    logic                  hbl_fired_reg, hbl_fired_next;
    logic                  lyc_fired_reg, lyc_fired_next;

    // output register and skid stage
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    result_t res;

    logic                  in_accept;
    logic [DELTA_W-1:0]    delta;

    // line counter path
    logic [LINE_CNT_W:0]   line_sum, line_rem;
    logic                  line_wrap;
    logic [LINE_W:0]       line_inc;
    logic                  at_visible;

    // mode counter path
    logic [MODE_CNT_W:0]   mode_sum, mode_rem;
    logic [MODE_DUR_W-1:0] mode_dur;
    logic                  mode_switch;
    mode_state_t           mode_step;

    // stat sources
    logic                  oam_irq, vbl_mode_irq, hbl_irq, lyc_irq, lyc_match;

    assign in_accept = s_tvalid && s_tready;
    assign delta     = s_tdata[DELTA_W-1:0];
    assign s_tready  = !skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_reg};

    // register writes: the user must write only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cycles_reg <= LINE_CYCLES_RST;
            oam_cycles_reg  <= OAM_CYCLES_RST;
            xfer_cycles_reg <= XFER_CYCLES_RST;
            hbl_cycles_reg  <= HBL_CYCLES_RST;
            vbl_cycles_reg  <= VBL_CYCLES_RST;
            lyc_value_reg   <= '0;
            irq_en_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_CYCLES: line_cycles_reg <= cfg_data[LINE_CYC_W-1:0];
                CFG_OAM_CYCLES:  oam_cycles_reg  <= cfg_data[MODE_DUR_W-1:0];
                CFG_XFER_CYCLES: xfer_cycles_reg <= cfg_data[MODE_DUR_W-1:0];
                CFG_HBL_CYCLES:  hbl_cycles_reg  <= cfg_data[MODE_DUR_W-1:0];
                CFG_VBL_CYCLES:  vbl_cycles_reg  <= cfg_data[MODE_DUR_W-1:0];
                CFG_LYC_VALUE:   lyc_value_reg   <= cfg_data[LINE_W-1:0];
                CFG_IRQ_ENABLES: irq_en_reg      <= cfg_data[IRQ_EN_W-1:0];
                default:         ;
            endcase
        end
    end

    // line counter: at most one line advance per word, the rest stays counted
    always_comb
    begin
        line_sum  = {1'b0, line_cnt_reg} + (LINE_CNT_W+1)'(delta);
        line_wrap = line_sum >= (LINE_CNT_W+1)'(line_cycles_reg);
        line_rem  = line_wrap ? line_sum - (LINE_CNT_W+1)'(line_cycles_reg) : line_sum;
        // the count can outgrow a lowered line length, so it saturates
        line_cnt_next = line_rem[LINE_CNT_W] ? LINE_CNT_MAX : line_rem[LINE_CNT_W-1:0];

        line_inc   = {1'b0, line_reg} + (LINE_W+1)'(1);
        at_visible = line_inc == VisLines;

        if (line_wrap)
        begin
            line_next      = (line_inc >= TotalLines) ? '0 : line_inc[LINE_W-1:0];
            vbl_fired_next = at_visible;
        end
        else
        begin
            line_next      = line_reg;
            vbl_fired_next = vbl_fired_reg;
        end
    end

    // mode sequencer: oam scan, transfer, hblank, vblank, one switch per word
    always_comb
    begin
        unique case (mode_reg)
            ST_OAM:    mode_dur = oam_cycles_reg;
            ST_XFER:   mode_dur = xfer_cycles_reg;
            ST_HBLANK: mode_dur = hbl_cycles_reg;
            ST_VBLANK: mode_dur = vbl_cycles_reg;
            default:   mode_dur = oam_cycles_reg;
        endcase

        mode_sum    = {1'b0, mode_cnt_reg} + (MODE_CNT_W+1)'(delta);
        mode_switch = mode_sum >= (MODE_CNT_W+1)'(mode_dur);
        mode_rem    = mode_switch ? mode_sum - (MODE_CNT_W+1)'(mode_dur) : mode_sum;
        mode_cnt_next = mode_rem[MODE_CNT_W] ? MODE_CNT_MAX : mode_rem[MODE_CNT_W-1:0];

        // vblank is only entered once the updated line is past the visible area
        unique case (mode_reg)
            ST_OAM:    mode_step = ST_XFER;
            ST_XFER:   mode_step = ST_HBLANK;
            ST_HBLANK: mode_step = ({1'b0, line_next} < VisLines) ? ST_OAM : ST_VBLANK;
            ST_VBLANK: mode_step = ST_OAM;
            default:   mode_step = ST_OAM;
        endcase

        mode_next      = mode_switch ? mode_step : mode_reg;
        oam_irq        = mode_switch && (mode_step == ST_OAM) && irq_en_reg[IRQ_EN_OAM];
        vbl_mode_irq   = mode_switch && (mode_step == ST_VBLANK) && irq_en_reg[IRQ_EN_VBLANK];
        // hblank interrupt fires once per stay, rearmed by any other mode entry
        hbl_irq        = mode_switch && (mode_step == ST_HBLANK) &&
                         irq_en_reg[IRQ_EN_HBLANK] && !hbl_fired_reg;
        if (mode_switch)
            hbl_fired_next = (mode_step == ST_HBLANK) ?
                             (hbl_fired_reg || irq_en_reg[IRQ_EN_HBLANK]) : 1'b0;
        else
            hbl_fired_next = hbl_fired_reg;
    end

    // ly == lyc compare, interrupt on the rising match only
    always_comb
    begin
        lyc_match      = line_next == lyc_value_reg;
        lyc_irq        = lyc_match && irq_en_reg[IRQ_EN_LYC] && !lyc_fired_reg;
        lyc_fired_next = lyc_match && (lyc_fired_reg || irq_en_reg[IRQ_EN_LYC]);

        res.scanline     = line_next;
        res.mode         = mode_code(mode_next);
        res.line_match   = lyc_match;
        res.vblank_irq   = line_wrap && at_visible && !vbl_fired_reg;
        res.stat_irq     = oam_irq || vbl_mode_irq || hbl_irq || lyc_irq;
        res.draw_request = mode_switch && (mode_step == ST_XFER);
        res.new_line     = line_wrap;
    end

    // state update on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cnt_reg  <= '0;
            mode_cnt_reg  <= '0;
            line_reg      <= '0;
            mode_reg      <= ST_OAM;
            vbl_fired_reg <= 1'b0;
            hbl_fired_reg <= 1'b0;
            lyc_fired_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            line_cnt_reg  <= line_cnt_next;
            mode_cnt_reg  <= mode_cnt_next;
            line_reg      <= line_next;
            mode_reg      <= mode_next;
            vbl_fired_reg <= vbl_fired_next;
            hbl_fired_reg <= hbl_fired_next;
            lyc_fired_reg <= lyc_fired_next;
        end
    end

    // output register with skid: a stalled result parks in the skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (in_accept)
            skid_reg <= res;
    end

    // checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output register is empty");

    a_scanline_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, out_reg.scanline} < TotalLines))
        else $error("scanline beyond the last line");

    a_vblank_irq_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.vblank_irq) |->
            (out_reg.new_line && ({1'b0, out_reg.scanline} == VisLines)))
        else $error("vblank interrupt away from the first blank line");

    a_draw_in_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.draw_request) |-> (out_reg.mode == MODE_XFER))
        else $error("draw request outside transfer mode");

endmodule
